// File: rtl/rhwa_pkg.sv
// Shared types and constants for the RGB hue window average block.
package rhwa_pkg;

    localparam int PIX_W       = 8;
    localparam int NUM_W       = 14;
    localparam int QUO_W       = 6;
    localparam int DIV_STEPS   = 6;
    localparam int STEP_W      = 3;
    localparam int ACC_W       = 12;
    localparam int COUNT_W     = 4;
    localparam int WIN_W       = 5;
    localparam int RECIP_SHIFT = 16;

    localparam logic [PIX_W-1:0] GRAY_HUE       = 8'd255;
    localparam logic [PIX_W-1:0] HUE_RED_BASE   = 8'd42;
    localparam logic [PIX_W-1:0] HUE_GREEN_BASE = 8'd126;
    localparam logic [PIX_W-1:0] HUE_BLUE_BASE  = 8'd210;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_HUE,
        S_AVG_MUL,
        S_AVG_FIX,
        S_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_step;
        logic hue_step;
        logic avg_mul;
        logic avg_fix;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_pixel;
    } dp_status_t;

endpackage

// File: rtl/rgb_hue_window_average.sv
// Top level of the RGB hue window average block.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   pixel   | in        | in_valid / in_stall | red, green, blue
//   result  | out       | out_valid/out_stall | pixel_hue, window_average, average_valid
//
// One pixel at a time; a window's last pixel also runs the average steps.
// Hue comes from the six-step shift-subtract hue divider.
// Reset clears the window sum, the pixel count and the result valid.
// A stalled result holds in the output register; a new pixel is still
// taken and waits in the write step until that register frees up.
module rgb_hue_window_average
    import rhwa_pkg::*;
#(
    parameter int WINDOW_PIXELS = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] pixel_hue,
    output logic [PIX_W-1:0] window_average,
    output logic             average_valid
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rhwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rhwa_datapath #(
        .WINDOW_PIXELS (WINDOW_PIXELS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .pixel_hue      (pixel_hue),
        .window_average (window_average),
        .average_valid  (average_valid)
    );

endmodule

// File: rtl/rhwa_ctrl.sv
// Controller state machine for the RGB hue window average block.
module rhwa_ctrl
    import rhwa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_HUE;
                end
            end
            S_HUE:
            begin
                cmd.hue_step = 1'b1;
                state_next   = status.last_pixel ? S_AVG_MUL : S_WRITE;
            end
            S_AVG_MUL:
            begin
                cmd.avg_mul = 1'b1;
                state_next  = S_AVG_FIX;
            end
            S_AVG_FIX:
            begin
                cmd.avg_fix = 1'b1;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

endmodule

// File: rtl/rhwa_datapath.sv
// Datapath: sector select, hue divider, window accumulator and average.
module rhwa_datapath
    import rhwa_pkg::*;
#(
    parameter int WINDOW_PIXELS = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    output logic [PIX_W-1:0] pixel_hue,
    output logic [PIX_W-1:0] window_average,
    output logic             average_valid
);

    localparam logic [WIN_W-1:0]     WIN_CONST = WIN_W'(WINDOW_PIXELS);
    localparam logic [RECIP_SHIFT:0] RECIP     =
        (RECIP_SHIFT+1)'((1 << RECIP_SHIFT) / WINDOW_PIXELS);

    logic [PIX_W-1:0]   red_reg, green_reg, blue_reg;
    logic [PIX_W-1:0]   delta_reg, base_reg, rem_reg, hue_reg, avg_reg;
    logic               gray_reg, neg_reg, last_reg;
    logic [QUO_W-1:0]   nbits_reg, quo_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [ACC_W-1:0]   acc_reg, q0_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [PIX_W-1:0]   pixel_hue_reg, window_average_reg;
    logic               average_valid_reg;

    logic [PIX_W-1:0]         mx, mn, delta, base, opa, opb, mag;
    logic                     gray, neg;
    logic [NUM_W-1:0]         num;
    logic [PIX_W:0]           trial;
    logic                     trial_ge;
    logic [PIX_W-1:0]         rem_next;
    logic [PIX_W-1:0]         hue;
    logic                     last;
    logic [ACC_W+RECIP_SHIFT:0] recip_prod;
    logic [ACC_W+WIN_W-1:0]   back_prod;
    logic [ACC_W-1:0]         avg_rem;
    logic [ACC_W-1:0]         avg_fixed;

    always_comb
    begin
        mx = red_reg;
        mn = red_reg;
        if (green_reg > mx) mx = green_reg;
        if (blue_reg > mx)  mx = blue_reg;
        if (green_reg < mn) mn = green_reg;
        if (blue_reg < mn)  mn = blue_reg;
        delta = mx - mn;
        gray  = ({delta, 1'b0} <= {1'b0, mx});
        priority if (red_reg == mx)
        begin
            base = HUE_RED_BASE;
            opa  = green_reg;
            opb  = blue_reg;
        end
        else if (green_reg == mx)
        begin
            base = HUE_GREEN_BASE;
            opa  = blue_reg;
            opb  = red_reg;
        end
        else
        begin
            base = HUE_BLUE_BASE;
            opa  = red_reg;
            opb  = green_reg;
        end
        neg = (opa < opb);
        mag = neg ? (opb - opa) : (opa - opb);
        num = NUM_W'({mag, 5'b0}) + NUM_W'({mag, 3'b0}) + NUM_W'({mag, 1'b0});
    end

    always_comb
    begin
        trial    = {rem_reg, nbits_reg[QUO_W-1]};
        trial_ge = (trial >= {1'b0, delta_reg});
        rem_next = trial_ge ? PIX_W'(trial - {1'b0, delta_reg}) : trial[PIX_W-1:0];
    end

    always_comb
    begin
        if (gray_reg)
        begin
            hue = GRAY_HUE;
        end
        else if (neg_reg)
        begin
            hue = base_reg - PIX_W'(quo_reg);
        end
        else
        begin
            hue = base_reg + PIX_W'(quo_reg);
        end
        last = (WIN_W'(count_reg) + WIN_W'(1)) >= WIN_CONST;
    end

    assign recip_prod = acc_reg * RECIP;
    assign back_prod  = q0_reg * WIN_CONST;
    assign avg_rem    = acc_reg - back_prod[ACC_W-1:0];
    assign avg_fixed  = (avg_rem >= ACC_W'(WIN_CONST)) ? (q0_reg + ACC_W'(1)) : q0_reg;

    assign status.div_done   = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.last_pixel = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            if (cmd.prep)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.hue_step)
            begin
                acc_reg   <= acc_reg + ACC_W'(hue);
                count_reg <= last ? '0 : (count_reg + COUNT_W'(1));
            end
            else if (cmd.avg_fix)
            begin
                acc_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
        if (cmd.prep)
        begin
            delta_reg <= delta;
            gray_reg  <= gray;
            neg_reg   <= neg;
            base_reg  <= base;
            rem_reg   <= num[NUM_W-1 -: PIX_W];
            nbits_reg <= num[QUO_W-1:0];
            quo_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg   <= rem_next;
            nbits_reg <= {nbits_reg[QUO_W-2:0], 1'b0};
            quo_reg   <= {quo_reg[QUO_W-2:0], trial_ge};
        end
        if (cmd.hue_step)
        begin
            hue_reg  <= hue;
            last_reg <= last;
            avg_reg  <= '0;
        end
        if (cmd.avg_mul)
        begin
            q0_reg <= recip_prod[RECIP_SHIFT +: ACC_W];
        end
        if (cmd.avg_fix)
        begin
            avg_reg <= avg_fixed[PIX_W-1:0];
        end
        if (cmd.out_load)
        begin
            pixel_hue_reg      <= hue_reg;
            window_average_reg <= avg_reg;
            average_valid_reg  <= last_reg;
        end
    end

    assign pixel_hue      = pixel_hue_reg;
    assign window_average = window_average_reg;
    assign average_valid  = average_valid_reg;

endmodule

// File: rtl/rhwa_checker.sv
// Port-level checker for the RGB hue window average block, with its bind.
module rhwa_checker
    import rhwa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [PIX_W-1:0] red,
    input logic [PIX_W-1:0] green,
    input logic [PIX_W-1:0] blue,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] pixel_hue,
    input logic [PIX_W-1:0] window_average,
    input logic             average_valid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_hue)
            && $stable(window_average) && $stable(average_valid))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while previous one in progress");

    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !average_valid |-> window_average == 8'd0)
        else $error("average shown outside window end");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pixel_hue <= 8'd252 || pixel_hue == GRAY_HUE)
        else $error("hue out of range");

endmodule

bind rgb_hue_window_average rhwa_checker u_rhwa_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for the RGB hue window average block.
module tb
    import rhwa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = 9;
    localparam int SECTOR_STEP = 42;
    localparam int NUM_RANDOM  = 950;
    localparam int SETTLE      = 30;
    localparam int LIMIT       = 250000;

    typedef struct {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        int               gap_pct;
        int               stall_pct;
        bit               drain;
    } pixel_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] avg;
        logic             avg_valid;
    } hue_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [PIX_W-1:0] red = '0;
    logic [PIX_W-1:0] green = '0;
    logic [PIX_W-1:0] blue = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [PIX_W-1:0] pixel_hue;
    logic [PIX_W-1:0] window_average;
    logic             average_valid;

    pixel_req_t  pixel_queue[$];
    hue_result_t hue_expected[$];
    int          stall_pct = 0;
    int          n_sent = 0;
    int          n_got = 0;
    int          errors = 0;
    int          cycles = 0;
    logic [ACC_W-1:0]   wnd_sum = '0;
    logic [COUNT_W-1:0] wnd_count = '0;

    rgb_hue_window_average #(
        .WINDOW_PIXELS(WINDOW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel_hue(pixel_hue),
        .window_average(window_average),
        .average_valid(average_valid)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [PIX_W-1:0] hue_of_pixel(logic [PIX_W-1:0] r,
                                                      logic [PIX_W-1:0] g,
                                                      logic [PIX_W-1:0] b);
        int ri;
        int gi;
        int bi;
        int mx;
        int mn;
        int dl;
        ri = r;
        gi = g;
        bi = b;
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        dl = mx - mn;
        if (2 * dl <= mx)
            return GRAY_HUE;
        if (ri == mx)
            return 8'(int'(HUE_RED_BASE) + (SECTOR_STEP * (gi - bi)) / dl);
        if (gi == mx)
            return 8'(int'(HUE_GREEN_BASE) + (SECTOR_STEP * (bi - ri)) / dl);
        return 8'(int'(HUE_BLUE_BASE) + (SECTOR_STEP * (ri - gi)) / dl);
    endfunction

    // accept, predict, then present the next request
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        hue_result_t  res;
        logic [ACC_W-1:0] sum;
        bit           taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            red      <= '0;
            green    <= '0;
            blue     <= '0;
        end
        else
        begin
            taken = in_valid && !in_stall;
            if (taken)
            begin
                res.hue = hue_of_pixel(red, green, blue);
                sum = wnd_sum + ACC_W'(res.hue);
                if (int'(wnd_count) + 1 >= WINDOW)
                begin
                    res.avg       = PIX_W'(sum / WINDOW);
                    res.avg_valid = 1'b1;
                    wnd_sum       = '0;
                    wnd_count     = '0;
                end
                else
                begin
                    res.avg       = '0;
                    res.avg_valid = 1'b0;
                    wnd_sum       = sum;
                    wnd_count     = wnd_count + 1'b1;
                end
                hue_expected.push_back(res);
                n_sent <= n_sent + 1;
            end
            if (!in_valid || taken)
            begin
                if (pixel_queue.size() > 0
                    && !(pixel_queue[0].drain && (taken || n_sent != n_got))
                    && $urandom_range(99) >= pixel_queue[0].gap_pct)
                begin
                    in_valid  <= 1'b1;
                    red       <= pixel_queue[0].r;
                    green     <= pixel_queue[0].g;
                    blue      <= pixel_queue[0].b;
                    stall_pct <= pixel_queue[0].stall_pct;
                    pixel_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // check each result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_got <= n_got + 1;
                if (hue_expected.size() == 0)
                begin
                    $error("result with no request outstanding: pixel_hue %0d", pixel_hue);
                    errors++;
                end
                else
                begin
                    if (pixel_hue !== hue_expected[0].hue)
                    begin
                        $error("pixel_hue: expected %0d, got %0d",
                               hue_expected[0].hue, pixel_hue);
                        errors++;
                    end
                    if (window_average !== hue_expected[0].avg)
                    begin
                        $error("window_average: expected %0d, got %0d",
                               hue_expected[0].avg, window_average);
                        errors++;
                    end
                    if (average_valid !== hue_expected[0].avg_valid)
                    begin
                        $error("average_valid: expected %0d, got %0d",
                               hue_expected[0].avg_valid, average_valid);
                        errors++;
                    end
                    hue_expected.pop_front();
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        pixel_req_t   req;
        logic [PIX_W-1:0] c[3];
        logic [PIX_W-1:0] directed[$];
        int           i;
        int           j;
        int           k;
        int           kind;
        int           base;
        int           lo;

        // black, white, primaries, ties, gray boundary, negative and truncated quotients
        directed = {
            8'd0,   8'd0,   8'd0,
            8'd255, 8'd255, 8'd255,
            8'd255, 8'd0,   8'd0,
            8'd0,   8'd255, 8'd0,
            8'd0,   8'd0,   8'd255,
            8'd255, 8'd255, 8'd0,
            8'd0,   8'd255, 8'd255,
            8'd255, 8'd0,   8'd255,
            8'd200, 8'd100, 8'd100,
            8'd201, 8'd100, 8'd100,
            8'd255, 8'd0,   8'd10,
            8'd255, 8'd0,   8'd254,
            8'd10,  8'd255, 8'd0,
            8'd0,   8'd255, 8'd1,
            8'd254, 8'd0,   8'd255,
            8'd0,   8'd1,   8'd255,
            8'd1,   8'd0,   8'd0,
            8'd170, 8'd85,  8'd127
        };
        for (i = 0; i < directed.size() / 3; i++)
        begin
            req.r         = directed[3 * i];
            req.g         = directed[3 * i + 1];
            req.b         = directed[3 * i + 2];
            req.gap_pct   = 15;
            req.stall_pct = 86;
            req.drain     = (i == 9);
            pixel_queue.push_back(req);
        end

        for (i = 0; i < NUM_RANDOM; i++)
        begin
            kind = $urandom_range(9);
            for (k = 0; k < 3; k++)
                c[k] = PIX_W'($urandom_range(255));
            if (kind == 0)
            begin
                for (k = 0; k < 3; k++)
                    c[k] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            else if (kind <= 2)
            begin
                base = $urandom_range(1, 255);
                lo   = base / 2 + $urandom_range(2);
                if (lo > 0) lo = lo - 1;
                if (lo > base) lo = base;
                for (k = 0; k < 3; k++)
                    c[k] = PIX_W'($urandom_range(base, lo));
                j = $urandom_range(2);
                c[j] = PIX_W'(base);
                c[(j + 1 + $urandom_range(1)) % 3] = PIX_W'(lo);
            end
            else if (kind == 3)
            begin
                j = $urandom_range(2);
                if (j == 0) c[1] = c[0];
                else if (j == 1) c[2] = c[0];
                else c[2] = c[1];
            end
            req.r = c[0];
            req.g = c[1];
            req.b = c[2];
            if (i < NUM_RANDOM / 3)
            begin
                req.gap_pct   = 15;
                req.stall_pct = 86;
            end
            else if (i < 2 * NUM_RANDOM / 3)
            begin
                req.gap_pct   = 86;
                req.stall_pct = 15;
            end
            else
            begin
                req.gap_pct   = 0;
                req.stall_pct = 0;
            end
            req.drain = (i == NUM_RANDOM / 3) || (i == 2 * NUM_RANDOM / 3)
                        || ($urandom_range(199) == 0);
            pixel_queue.push_back(req);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pixel_queue.size() > 0 || in_valid || n_sent != n_got)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (hue_expected.size() != 0)
        begin
            $error("%0d predicted results never arrived", hue_expected.size());
            errors++;
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/rhwa_pkg.sv
rtl/rhwa_ctrl.sv
rtl/rhwa_datapath.sv
rtl/rgb_hue_window_average.sv
rtl/rhwa_checker.sv
dv/tb.sv
